[rtl/pwp_pkg.sv]
package pwp_pkg;

  localparam int PWP_MAX_LEN = 4096;
  localparam int PWP_EXP_DEPTH = 256;

  localparam int MODE_W = 3;
  localparam int LEN_W = 13;
  localparam int POS_W = 12;
  localparam int NUM_W = 32;
  localparam int SUM_W = 48;
  localparam int WEIGHT_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] CORE_LEN_RESET = 13'd50;

  localparam logic [MODE_W-1:0] MODE_UNIFORM  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRI      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRI_CORE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RECT     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd3;

  localparam logic [63:0] EXP_STEP_Q31 = 64'd2145766348;
  localparam logic [63:0] Q31_ONE = 64'd2147483648;
  localparam logic [63:0] Q31_HALF = 64'd1073741824;

  typedef enum logic [3:0] {
    PWP_IDLE,
    PWP_CHECK,
    PWP_WALK,
    PWP_DRAIN,
    PWP_FINISH,
    PWP_NUMER,
    PWP_NUMWAIT,
    PWP_DIV,
    PWP_DONE
  } pwp_state_t;

  typedef struct packed {
    logic             issue;
    logic [LEN_W-1:0] idx;
  } pwp_num_req_t;

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] num;
  } pwp_num_rsp_t;

  // Entry idx of the exponential table, exp(-d*d/1250) in Q1.31, built by
  // repeated rounded multiplies. Used at elaboration only.
  function automatic logic [31:0] pwp_exp_val(input int idx);
    logic [63:0] g;
    logic [63:0] a;
    logic [63:0] a2;
    g = Q31_ONE;
    a = EXP_STEP_Q31;
    a2 = (a * a + Q31_HALF) >> 31;
    for (int i = 0; i < idx; i++) begin
      g = (g * a + Q31_HALF) >> 31;
      a = (a * a2 + Q31_HALF) >> 31;
    end
    return g[31:0];
  endfunction

endpackage

[rtl/pwp_in_if.sv]
interface pwp_in_if
  import pwp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  seq_len;
  logic [POS_W-1:0]  position;

  modport source (output valid, mode, seq_len, position, input ready);
  modport sink (input valid, mode, seq_len, position, output ready);
endinterface

[rtl/pwp_out_if.sv]
interface pwp_out_if
  import pwp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [STATUS_W-1:0] status;

  modport source (output valid, weight, status, input ready);
  modport sink (input valid, weight, status, output ready);
endinterface

[rtl/positional_weight_profile.sv]
// Positional weight profile.
// A request on in_req carries mode, seq_len and position; one result leaves on
// out_req with the normalized weight (Q1.31, truncated) and a status code.
// The user must write the core width for plateau and rectangle modes through
// cfg_wr_en and cfg_wr_data only while the block is idle; the block does not
// enforce this. A write empties the sum cache. The block handles one request
// at a time: in_req.ready is high only while the controller is idle, and a
// result waiting in the output register does not keep the next request out.
// A request with a bad mode or position goes from the check straight to the
// result. On a cache hit the numerator stage is read once and the bit-serial
// divider forms the 32-bit quotient, unless the cached sum is zero. On a cache
// miss a sum walk comes first, one position per cycle through the numerator stage.
// Reset empties the cache, sets the core width to 50 and drops any result.
// When the receiver stalls, the result is held in the output register; a
// finished second request waits in the controller until the register frees.
module positional_weight_profile
  import pwp_pkg::*;
#(
  parameter int MAX_LEN = PWP_MAX_LEN,
  parameter int EXP_TABLE_DEPTH = PWP_EXP_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  pwp_in_if.sink           in_req,
  pwp_out_if.source        out_req,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  pwp_state_t state_r, state_nxt;

  logic [MODE_W-1:0]   mode_r;
  logic [LEN_W-1:0]    len_r;
  logic [POS_W-1:0]    pos_r;
  logic [LEN_W-1:0]    hw_r;
  logic [LEN_W-1:0]    hw_nxt;
  logic [LEN_W-1:0]    core_len_r;
  logic [SUM_W-1:0]    cached_sum_r;
  logic [LEN_W-1:0]    cached_len_r;
  logic [MODE_W-1:0]   cached_mode_r;
  logic                cache_valid_r;
  logic [LEN_W-1:0]    walk_r;
  logic [SUM_W-1:0]    acc_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                out_valid_r;
  logic [WEIGHT_W-1:0] out_weight_r;
  logic [STATUS_W-1:0] out_status_r;

  logic bad_mode;
  logic bad_pos;
  logic hit;
  logic out_free;
  logic out_load;
  logic div_start;
  logic div_done;
  logic [WEIGHT_W-1:0] div_quo;
  logic accumulate;

  pwp_num_req_t num_req;
  pwp_num_rsp_t num_rsp;

  assign bad_mode = (mode_r > MODE_RECT);
  assign bad_pos  = (len_r == '0) || (int'(len_r) > MAX_LEN) || ({1'b0, pos_r} >= len_r);
  assign hit = cache_valid_r && (cached_mode_r == mode_r) && (cached_len_r == len_r);
  assign out_free = !out_valid_r || out_req.ready;

  always_comb begin
    hw_nxt = '0;
    if (mode_r == MODE_TRI_CORE) begin
      hw_nxt = {1'b0, core_len_r[LEN_W-1:1]};
      if ({core_len_r[LEN_W-1:1], 1'b0} >= len_r) begin
        hw_nxt = {2'b00, len_r[LEN_W-1:2]};
      end
    end else if (mode_r == MODE_RECT) begin
      hw_nxt = {1'b0, core_len_r[LEN_W-1:1]};
      if (core_len_r >= len_r) begin
        hw_nxt = {2'b00, len_r[LEN_W-1:2]};
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PWP_IDLE: begin
        if (in_req.valid) begin
          state_nxt = PWP_CHECK;
        end
      end
      PWP_CHECK: begin
        if (bad_mode || bad_pos) begin
          state_nxt = PWP_DONE;
        end else if (hit) begin
          state_nxt = PWP_NUMER;
        end else begin
          state_nxt = PWP_WALK;
        end
      end
      PWP_WALK: begin
        if (walk_r == len_r - LEN_W'(1)) begin
          state_nxt = PWP_DRAIN;
        end
      end
      PWP_DRAIN:   state_nxt = PWP_FINISH;
      PWP_FINISH:  state_nxt = PWP_NUMER;
      PWP_NUMER:   state_nxt = PWP_NUMWAIT;
      PWP_NUMWAIT: state_nxt = (cached_sum_r == '0) ? PWP_DONE : PWP_DIV;
      PWP_DIV: begin
        if (div_done) begin
          state_nxt = PWP_DONE;
        end
      end
      PWP_DONE: begin
        if (out_free) begin
          state_nxt = PWP_IDLE;
        end
      end
      default: state_nxt = PWP_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    num_req.issue = 1'b0;
    num_req.idx   = walk_r;
    div_start     = 1'b0;
    accumulate    = 1'b0;
    status_nxt    = status_r;
    out_load      = 1'b0;
    case (state_r)
      PWP_CHECK: begin
        if (bad_mode) begin
          status_nxt = ST_BAD_MODE;
        end else if (bad_pos) begin
          status_nxt = ST_BAD_POS;
        end else begin
          status_nxt = ST_OK;
        end
      end
      PWP_WALK: begin
        num_req.issue = 1'b1;
        accumulate    = 1'b1;
      end
      PWP_DRAIN: accumulate = 1'b1;
      PWP_NUMER: begin
        num_req.issue = 1'b1;
        num_req.idx   = {1'b0, pos_r};
      end
      PWP_NUMWAIT: begin
        if (cached_sum_r == '0) begin
          status_nxt = ST_ZERO_SUM;
        end else begin
          div_start = 1'b1;
        end
      end
      PWP_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= PWP_IDLE;
      core_len_r    <= CORE_LEN_RESET;
      cached_sum_r  <= '0;
      cached_len_r  <= '0;
      cached_mode_r <= '0;
      cache_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        core_len_r    <= cfg_wr_data;
        cache_valid_r <= 1'b0;
      end else if (state_r == PWP_FINISH) begin
        cached_sum_r  <= acc_r;
        cached_len_r  <= len_r;
        cached_mode_r <= mode_r;
        cache_valid_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      mode_r <= in_req.mode;
      len_r  <= in_req.seq_len;
      pos_r  <= in_req.position;
    end
    status_r <= status_nxt;
    if (state_r == PWP_CHECK) begin
      hw_r   <= hw_nxt;
      walk_r <= '0;
      acc_r  <= '0;
    end else begin
      if (num_req.issue && state_r == PWP_WALK) begin
        walk_r <= walk_r + LEN_W'(1);
      end
      if (accumulate && num_rsp.vld) begin
        acc_r <= acc_r + SUM_W'(num_rsp.num);
      end
    end
    if (out_load) begin
      out_weight_r <= (status_r == ST_OK) ? div_quo : '0;
      out_status_r <= status_r;
    end
  end

  pwp_numer #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_numer (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (num_req),
    .mode (mode_r),
    .len  (len_r),
    .hw   (hw_r),
    .rsp  (num_rsp)
  );

  pwp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .numer(num_rsp.num),
    .sum  (cached_sum_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_req.ready   = (state_r == PWP_IDLE);
  assign out_req.valid  = out_valid_r;
  assign out_req.weight = out_weight_r;
  assign out_req.status = out_status_r;

endmodule

[rtl/pwp_numer.sv]
module pwp_numer
  import pwp_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = PWP_EXP_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pwp_num_req_t      req,
  input  logic [MODE_W-1:0] mode,
  input  logic [LEN_W-1:0]  len,
  input  logic [LEN_W-1:0]  hw,
  output pwp_num_rsp_t      rsp
);

  localparam int AW = $clog2(EXP_TABLE_DEPTH);

  logic [31:0] rom [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [31:0] Val = pwp_exp_val(gi);
    assign rom[gi] = Val;
  end

  logic [LEN_W-1:0] h;
  logic [LEN_W-1:0] lo;
  logic [LEN_W-1:0] hi;
  logic [LEN_W-1:0] d;
  logic [NUM_W-1:0] num_nxt;
  logic [NUM_W-1:0] num_r;
  logic             vld_r;

  assign h  = {1'b0, len[LEN_W-1:1]};
  assign lo = h - hw;
  assign hi = h + hw;
  assign d  = (req.idx >= h) ? (req.idx - h) : (h - req.idx);

  always_comb begin
    case (mode)
      MODE_UNIFORM: num_nxt = NUM_W'(1);
      MODE_GAUSS: begin
        if (int'(d) < EXP_TABLE_DEPTH) begin
          num_nxt = rom[d[AW-1:0]];
        end else begin
          num_nxt = '0;
        end
      end
      MODE_TRI, MODE_TRI_CORE: begin
        if (req.idx < lo) begin
          num_nxt = NUM_W'({req.idx, 1'b0});
        end else if (req.idx < hi) begin
          num_nxt = NUM_W'(len - {hw[LEN_W-2:0], 1'b0});
        end else begin
          num_nxt = NUM_W'({({h[LEN_W-2:0], 1'b0} - req.idx), 1'b0});
        end
      end
      default: num_nxt = NUM_W'((req.idx >= lo) && (req.idx < hi));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      num_r <= num_nxt;
    end
  end

  assign rsp.vld = vld_r;
  assign rsp.num = num_r;

endmodule

[rtl/pwp_div.sv]
module pwp_div
  import pwp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    numer,
  input  logic [SUM_W-1:0]    sum,
  output logic                done,
  output logic [WEIGHT_W-1:0] quo
);

  // Long division of numer * 2^31 by sum, one quotient bit a cycle. The top
  // part numer >> 1 is already below sum since numer never exceeds sum.
  logic [SUM_W-1:0]    rem_r;
  logic [SUM_W-1:0]    rem_nxt;
  logic [WEIGHT_W-1:0] dsr_r;
  logic [WEIGHT_W-1:0] quo_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic [SUM_W:0]      trial;
  logic [SUM_W:0]      diff;
  logic                qbit;

  assign trial = {rem_r, dsr_r[WEIGHT_W-1]};
  assign diff  = trial - {1'b0, sum};
  assign qbit  = (trial >= {1'b0, sum});
  assign rem_nxt = qbit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SUM_W'(numer >> 1);
      dsr_r <= {numer[0], {(WEIGHT_W-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsr_r <= {dsr_r[WEIGHT_W-2:0], 1'b0};
      quo_r <= {quo_r[WEIGHT_W-2:0], qbit};
    end
  end

  assign done = busy_r && (cnt_r == 5'd31);
  assign quo  = quo_r;

endmodule

[rtl/pwp_checker.sv]
module pwp_checker
  import pwp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [WEIGHT_W-1:0] out_weight,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // Any flagged result carries a zero weight.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_weight == '0)
    else $error("nonzero weight with error status");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind positional_weight_profile pwp_checker u_pwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_req.valid),
  .out_ready (out_req.ready),
  .out_weight(out_req.weight),
  .out_status(out_req.status)
);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pwp_pkg::*;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [STATUS_W-1:0] status;
  } weight_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  pwp_in_if in_req();
  pwp_out_if out_req();

  positional_weight_profile i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_req    (out_req),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state.
  logic [31:0] gauss_tab [PWP_EXP_DEPTH];
  logic [LEN_W-1:0] core_width;
  logic [SUM_W-1:0] sum_cache;
  logic [LEN_W-1:0] len_cache;
  logic [MODE_W-1:0] mode_cache;
  bit cache_full;

  weight_result_t pending_weights[$];
  int errors;
  int results_seen;
  int status_seen [4];
  int send_idle_pct;
  int recv_stall_pct;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic void build_gauss_tab();
    longint unsigned g;
    longint unsigned a;
    longint unsigned a2;
    g = 64'd2147483648;
    a = 64'd2145766348;
    a2 = (a * a + 64'd1073741824) >> 31;
    for (int i = 0; i < PWP_EXP_DEPTH; i++) begin
      gauss_tab[i] = g[31:0];
      g = (g * a + 64'd1073741824) >> 31;
      a = (a * a2 + 64'd1073741824) >> 31;
    end
  endfunction

  function automatic int core_half(logic [MODE_W-1:0] mode, int len);
    int hw;
    hw = int'(core_width) / 2;
    if (mode == MODE_TRI_CORE) begin
      if (2 * hw >= len) hw = len / 4;
      return hw;
    end
    if (mode == MODE_RECT) begin
      if (int'(core_width) >= len) hw = len / 4;
      return hw;
    end
    return 0;
  endfunction

  function automatic longint unsigned profile_numer(logic [MODE_W-1:0] mode, int len, int hw,
                                                    int j);
    int h;
    int d;
    h = len / 2;
    case (mode)
      MODE_UNIFORM: return 1;
      MODE_GAUSS: begin
        d = (j >= h) ? j - h : h - j;
        return (d < PWP_EXP_DEPTH) ? longint'(gauss_tab[d]) : 0;
      end
      MODE_TRI, MODE_TRI_CORE: begin
        if (j < h - hw) return 2 * j;
        if (j < h + hw) return len - 2 * hw;
        return 2 * (2 * h - j);
      end
      default: return (j >= h - hw && j < h + hw) ? 1 : 0;
    endcase
  endfunction

  function automatic weight_result_t predict_weight(logic [MODE_W-1:0] mode,
                                                    logic [LEN_W-1:0] len,
                                                    logic [POS_W-1:0] pos);
    weight_result_t r;
    int hw;
    longint unsigned s;
    longint unsigned n;
    r.weight = '0;
    if (mode > MODE_RECT) begin
      r.status = ST_BAD_MODE;
      return r;
    end
    if (len == 0 || len > PWP_MAX_LEN || pos >= len) begin
      r.status = ST_BAD_POS;
      return r;
    end
    hw = core_half(mode, int'(len));
    if (cache_full && mode_cache == mode && len_cache == len) begin
      s = sum_cache;
    end else begin
      s = 0;
      for (int j = 0; j < int'(len); j++) s += profile_numer(mode, int'(len), hw, j);
      sum_cache = s[SUM_W-1:0];
      s = sum_cache;
      mode_cache = mode;
      len_cache = len;
      cache_full = 1'b1;
    end
    if (s == 0) begin
      r.status = ST_ZERO_SUM;
      return r;
    end
    n = profile_numer(mode, int'(len), hw, int'(pos));
    r.weight = WEIGHT_W'((n << 31) / s);
    r.status = ST_OK;
    return r;
  endfunction

  // Receiver: random stalls on the result channel.
  always @(posedge clk) begin
    out_req.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    weight_result_t exp_r;
    if (rst_n && out_req.valid && out_req.ready) begin
      results_seen++;
      status_seen[out_req.status]++;
      if (pending_weights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result weight %h status %0d", $time, out_req.weight,
                 out_req.status);
      end else begin
        exp_r = pending_weights.pop_front();
        if (out_req.weight !== exp_r.weight) begin
          errors++;
          $display("%0t: weight expected %h actual %h", $time, exp_r.weight, out_req.weight);
        end
        if (out_req.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_req.status);
        end
      end
    end
  end

  task automatic send_query(logic [MODE_W-1:0] mode, logic [LEN_W-1:0] len,
                            logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.mode <= mode;
    in_req.seq_len <= len;
    in_req.position <= pos;
    pending_weights.push_back(predict_weight(mode, len, pos));
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    in_req.valid <= 1'b0;
    // The block is busy in the cycle after a request anyway.
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  // Drains every expected result first, so the write lands with the block idle.
  task automatic write_core_len(logic [LEN_W-1:0] value);
    wait_drained();
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    core_width = value;
    cache_full = 1'b0;
    cfg_writes++;
  endtask

  task automatic test_directed();
    send_query(MODE_UNIFORM, 13'd1, 12'd0);
    send_query(MODE_UNIFORM, 13'd4096, 12'd4095);
    send_query(MODE_UNIFORM, 13'd4096, 12'd0);
    send_query(MODE_GAUSS, 13'd4096, 12'd2048);
    send_query(MODE_GAUSS, 13'd4096, 12'd0);
    send_query(MODE_GAUSS, 13'd600, 12'd555);
    send_query(MODE_GAUSS, 13'd1, 12'd0);
    send_query(MODE_TRI, 13'd1, 12'd0);
    send_query(MODE_TRI, 13'd7, 12'd3);
    send_query(MODE_TRI, 13'd7, 12'd6);
    send_query(MODE_TRI_CORE, 13'd100, 12'd50);
    send_query(MODE_TRI_CORE, 13'd100, 12'd10);
    send_query(MODE_TRI_CORE, 13'd40, 12'd20);
    send_query(MODE_RECT, 13'd100, 12'd25);
    send_query(MODE_RECT, 13'd100, 12'd24);
    send_query(MODE_RECT, 13'd3, 12'd1);
    send_query(3'd5, 13'd10, 12'd0);
    send_query(3'd7, 13'd8191, 12'd4095);
    send_query(MODE_UNIFORM, 13'd0, 12'd0);
    send_query(MODE_UNIFORM, 13'd4097, 12'd5);
    send_query(MODE_UNIFORM, 13'd8191, 12'd4095);
    send_query(MODE_TRI, 13'd10, 12'd10);
    send_query(MODE_GAUSS, 13'd20, 12'd4095);
    wait_drained();
  endtask

  task automatic test_core_extremes();
    logic [LEN_W-1:0] widths [5] = '{13'd0, 13'd1, 13'd4095, 13'd4096, 13'd3};
    foreach (widths[k]) begin
      write_core_len(widths[k]);
      send_query(MODE_RECT, 13'd9, 12'd4);
      send_query(MODE_RECT, 13'd9, 12'd0);
      send_query(MODE_TRI_CORE, 13'd9, 12'd4);
      send_query(MODE_TRI_CORE, 13'd64, 12'd31);
      send_query(MODE_RECT, 13'd2, 12'd1);
    end
    write_core_len(CORE_LEN_RESET);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return LEN_W'($urandom_range(64, 1));
    if (p < 96) return LEN_W'($urandom_range(512, 65));
    return LEN_W'($urandom_range(4096, 513));
  endfunction

  task automatic test_random(int count);
    int sent;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    int burst;
    int p;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 3) begin
        if ($urandom_range(1)) write_core_len(LEN_W'($urandom_range(4096, 0)));
        else write_core_len(LEN_W'($urandom_range(40, 0)));
      end
      // Pressure: let the pipeline empty before the next burst now and then.
      if ($urandom_range(99) < 4) wait_drained();
      mode = MODE_W'($urandom_range(4, 0));
      len = pick_len();
      burst = $urandom_range(8, 1);
      for (int b = 0; b < burst && sent < count; b++) begin
        p = $urandom_range(99);
        pos = POS_W'($urandom_range(int'(len) - 1, 0));
        if (p < 5) pos = '0;
        else if (p < 10) pos = POS_W'(len - LEN_W'(1));
        else if (p < 14) pos = POS_W'(len >> 1);
        if (p >= 94) begin
          // Noise: bad mode, bad length or a position past the end.
          case ($urandom_range(2))
            0: send_query(MODE_W'($urandom_range(7, 5)), LEN_W'($urandom), POS_W'($urandom));
            1: send_query(mode,
                          $urandom_range(1) ? 13'd0 : LEN_W'($urandom_range(8191, 4097)),
                          POS_W'($urandom));
            default: send_query(mode, len, POS_W'($urandom_range(4095, int'(len))));
          endcase
        end else begin
          send_query(mode, len, pos);
        end
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_req.valid = 1'b0;
    in_req.mode = '0;
    in_req.seq_len = '0;
    in_req.position = '0;
    errors = 0;
    results_seen = 0;
    cfg_writes = 0;
    status_seen = '{0, 0, 0, 0};
    core_width = CORE_LEN_RESET;
    cache_full = 1'b0;
    sum_cache = '0;
    len_cache = '0;
    mode_cache = '0;
    build_gauss_tab();
    send_idle_pct = 35;
    recv_stall_pct = 57;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_core_extremes();
    test_random(350);
    send_idle_pct = 57;
    recv_stall_pct = 35;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(350);

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d results (ok %0d, zero sum %0d, bad position %0d, bad mode %0d)",
             results_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("over %0d core width writes and three idle patterns", cfg_writes);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
